// ===== design/vsal_pkg.sv =====
// Shared types and constants for the vector step limiter.
`default_nettype none
package vsal_pkg;
  localparam int unsigned CompW = 24;
  localparam int unsigned OutW  = 21;
  localparam int unsigned LenW  = 20;
  localparam int unsigned CfgW  = 20;
  localparam int unsigned SqW   = 50;
  localparam int unsigned MagW  = 25;
  localparam logic CfgAccel = 1'b0;
  localparam logic CfgSpeed = 1'b1;
  localparam logic [LenW-1:0] AccelRst = 20'd1000;
  localparam logic [LenW-1:0] SpeedRst = 20'd10000;

  typedef struct packed {
    logic signed [CompW-1:0] z;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic signed [OutW-1:0] sz;
    logic signed [OutW-1:0] sy;
    logic signed [OutW-1:0] sx;
    logic [LenW-1:0] len;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_LIM, ST_DIV, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== design/vsal_front.sv =====
// Input side: registers a transaction into a two-entry queue.
`default_nettype none
module vsal_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire vsal_pkg::vec_t in_vec,
  input  wire logic         pop,
  output logic              q_valid,
  output vsal_pkg::vec_t    q_vec
);
  vsal_pkg::vec_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_vec    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_vec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop && q_valid};
    end
  end
endmodule
`default_nettype wire

// ===== design/vsal_back.sv =====
// Back end: magnitude, limits and scaling, one item at a time.
`default_nettype none
module vsal_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire vsal_pkg::vec_t    q_vec,
  output logic                   pop,
  input  wire logic [vsal_pkg::CfgW-1:0] accel,
  input  wire logic [vsal_pkg::CfgW-1:0] speed,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vsal_pkg::res_t         out_res
);
  localparam int unsigned CompW = vsal_pkg::CompW;
  localparam int unsigned SqW   = vsal_pkg::SqW;
  localparam int unsigned LenW  = vsal_pkg::LenW;
  localparam int unsigned OutW  = vsal_pkg::OutW;
  localparam int unsigned MagW  = vsal_pkg::MagW;
  localparam int unsigned NumW  = 43;

  vsal_pkg::state_t st_r, st_nxt;
  logic [CompW-1:0] a_r [3];
  logic [2:0] neg_r;
  logic [SqW-1:0] sum_r, rem_r;
  logic [SqW-1:0] root_r;
  logic [1:0] idx_r;
  logic [5:0] cnt_r;
  logic [LenW-1:0] last_r, len_r;
  logic [NumW-1:0] num_r;
  logic [NumW+1:0] drem_r;
  logic [OutW-1:0] quo_r [3];
  logic out_valid_r;
  vsal_pkg::res_t res_r;

  logic [CompW-1:0] cur_a;
  logic [2*CompW-1:0] sq;
  logic [SqW-1:0] bit_v, trial;
  logic [LenW:0] grow;
  logic [LenW-1:0] lim;
  logic [NumW+1:0] dsh;
  logic [NumW+1:0] magx;

  assign cur_a = a_r[idx_r];
  assign sq    = cur_a * cur_a;
  assign bit_v = {{(SqW-1){1'b0}}, 1'b1} << {cnt_r[4:0], 1'b0};
  assign trial = root_r + bit_v;
  assign grow  = {1'b0, last_r} + {1'b0, accel};
  always_comb begin
    lim = root_r[LenW-1:0];
    if (root_r > {{(SqW-LenW-1){1'b0}}, grow}) lim = grow[LenW-1:0];
    if ({{(SqW-LenW){1'b0}}, lim} > {{(SqW-LenW){1'b0}}, speed}) lim = speed;
    if (|root_r[SqW-1:LenW] && grow > {1'b0, speed}) lim = speed;
  end
  assign dsh  = {drem_r[NumW:0], num_r[NumW-1]};
  assign magx = {{(NumW+2-MagW){1'b0}}, root_r[MagW-1:0]};

  assign pop       = (st_r == vsal_pkg::ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      vsal_pkg::ST_IDLE: if (q_valid) st_nxt = vsal_pkg::ST_SQ;
      vsal_pkg::ST_SQ:   if (idx_r == 2'd2) st_nxt = vsal_pkg::ST_SQRT;
      vsal_pkg::ST_SQRT: if (cnt_r == 6'd0) st_nxt = vsal_pkg::ST_LIM;
      vsal_pkg::ST_LIM:  st_nxt = vsal_pkg::ST_DIV;
      vsal_pkg::ST_DIV:
        if (cnt_r == 6'd0 && idx_r == 2'd2) st_nxt = vsal_pkg::ST_OUT;
      vsal_pkg::ST_OUT:  if (!out_valid_r || out_ready) st_nxt = vsal_pkg::ST_IDLE;
      default:           st_nxt = vsal_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= vsal_pkg::ST_IDLE;
      last_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (st_r == vsal_pkg::ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        last_r <= len_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      vsal_pkg::ST_IDLE: begin
        a_r[0] <= q_vec.x[CompW-1] ? -q_vec.x : q_vec.x;
        a_r[1] <= q_vec.y[CompW-1] ? -q_vec.y : q_vec.y;
        a_r[2] <= q_vec.z[CompW-1] ? -q_vec.z : q_vec.z;
        neg_r  <= {q_vec.z[CompW-1], q_vec.y[CompW-1], q_vec.x[CompW-1]};
        sum_r  <= '0;
        idx_r  <= 2'd0;
      end
      vsal_pkg::ST_SQ: begin
        sum_r <= sum_r + {{(SqW-2*CompW){1'b0}}, sq};
        idx_r <= idx_r + 2'd1;
        if (idx_r == 2'd2) begin
          rem_r  <= sum_r + {{(SqW-2*CompW){1'b0}}, sq};
          root_r <= '0;
          cnt_r  <= 6'd24;
        end
      end
      vsal_pkg::ST_SQRT: begin
        // one result bit per cycle, classic digit-by-digit root
        if (rem_r >= trial) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_v;
        end else begin
          root_r <= root_r >> 1;
        end
        cnt_r <= cnt_r - 6'd1;
      end
      vsal_pkg::ST_LIM: begin
        len_r  <= (root_r == '0) ? '0 : lim;
        idx_r  <= 2'd0;
        num_r  <= {{(NumW-CompW){1'b0}}, a_r[0]} *
                  {{(NumW-LenW){1'b0}}, ((root_r == '0) ? '0 : lim)};
        drem_r <= '0;
        cnt_r  <= 6'd43;
      end
      vsal_pkg::ST_DIV: begin
        if (cnt_r != 6'd0) begin
          // restoring division, one quotient bit per cycle
          if (dsh >= magx) drem_r <= dsh - magx;
          else drem_r <= dsh;
          num_r <= {num_r[NumW-2:0], (dsh >= magx)};
          cnt_r <= cnt_r - 6'd1;
        end else begin
          // zero length covers the zero vector, where the divisor is zero
          quo_r[idx_r] <= (len_r == '0) ? '0 : num_r[OutW-1:0];
          idx_r  <= idx_r + 2'd1;
          num_r  <= {{(NumW-CompW){1'b0}},
                     a_r[(idx_r == 2'd2) ? 2'd2 : idx_r + 2'd1]} *
                    {{(NumW-LenW){1'b0}}, len_r};
          drem_r <= '0;
          cnt_r  <= 6'd43;
        end
      end
      vsal_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          res_r.len <= len_r;
          res_r.sx  <= neg_r[0] ? -quo_r[0] : quo_r[0];
          res_r.sy  <= neg_r[1] ? -quo_r[1] : quo_r[1];
          res_r.sz  <= neg_r[2] ? -quo_r[2] : quo_r[2];
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/vector_step_speed_accel_limiter.sv =====
// Top level of the vector step speed and acceleration limiter.
// channel | dir | tdata fields (low bit first)
// in_     | in  | disp_x[23:0], disp_y[47:24], disp_z[71:48]
// out_    | out | step_x[20:0], step_y[41:21], step_z[62:42], step_length[82:63]
// cfg_    | in  | index 0 accel limit, index 1 speed limit
// Per item the back end steps through dequeue, squaring of each component, a bit-serial
// root, a limit step, three restoring divisions and an output state.
// A two-entry queue lets the front accept while the back works; the output
// register holds until taken, stalling the back end in its output cycle.
// Reset is synchronous, active low; limits return to 1000 and 10000.
`default_nettype none
module vector_step_speed_accel_limiter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // disp_x, disp_y, disp_z
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // step_x, step_y, step_z, step_length
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [19:0] cfg_wdata
);
  logic [vsal_pkg::CfgW-1:0] accel_r, speed_r;
  logic q_valid, pop;
  vsal_pkg::vec_t in_vec, q_vec;
  vsal_pkg::res_t res;

  assign in_vec.x = in_tdata[23:0];
  assign in_vec.y = in_tdata[47:24];
  assign in_vec.z = in_tdata[71:48];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= vsal_pkg::AccelRst;
      speed_r <= vsal_pkg::SpeedRst;
    end else if (cfg_we) begin
      if (cfg_index == vsal_pkg::CfgAccel) accel_r <= cfg_wdata;
      else speed_r <= cfg_wdata;
    end
  end

  vsal_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_vec,
    .pop, .q_valid, .q_vec
  );

  vsal_back u_back (
    .clk, .rst_n, .q_valid, .q_vec, .pop, .accel(accel_r), .speed(speed_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {5'd0, res.len, res.sz, res.sy, res.sx};
endmodule
`default_nettype wire

// ===== dv/step_limit_checker.sv =====
// Checker for the vector step limiter: predicts each step and compares outputs.
module step_limit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata,
  output int          fail_count,
  output int          steps_pending
);
  logic [vsal_pkg::LenW-1:0] accel_lim, speed_lim, prev_len;
  logic [87:0] step_queue[$];

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] r, b, v;
    r = 0;
    v = n;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [vsal_pkg::OutW-1:0] scaled_comp(
      input logic signed [vsal_pkg::CompW-1:0] c,
      input logic [63:0] len,
      input logic [63:0] mag);
    logic [63:0] a, q;
    a = c[vsal_pkg::CompW-1] ? 64'(-$signed(64'(c))) : 64'(c);
    q = (a * len) / mag;
    if (c[vsal_pkg::CompW-1]) q = -q;
    return q[vsal_pkg::OutW-1:0];
  endfunction

  // Returns packed out_tdata and updates the stored step length.
  function automatic logic [87:0] limited_step(input logic [71:0] d);
    logic signed [vsal_pkg::CompW-1:0] x, y, z;
    logic [63:0] ax, ay, az, mag, len, grow;
    logic [vsal_pkg::OutW-1:0] sx, sy, sz;
    x = d[23:0];
    y = d[47:24];
    z = d[71:48];
    ax = x[vsal_pkg::CompW-1] ? 64'(-$signed(64'(x))) : 64'(x);
    ay = y[vsal_pkg::CompW-1] ? 64'(-$signed(64'(y))) : 64'(y);
    az = z[vsal_pkg::CompW-1] ? 64'(-$signed(64'(z))) : 64'(z);
    mag = floor_root(ax * ax + ay * ay + az * az);
    grow = 64'(prev_len) + 64'(accel_lim);
    len = mag;
    if (len > grow) len = grow;
    if (len > 64'(speed_lim)) len = 64'(speed_lim);
    if (mag == 0) begin
      len = 0;
      sx = 0; sy = 0; sz = 0;
    end else begin
      sx = scaled_comp(x, len, mag);
      sy = scaled_comp(y, len, mag);
      sz = scaled_comp(z, len, mag);
    end
    prev_len = len[vsal_pkg::LenW-1:0];
    return {5'd0, len[vsal_pkg::LenW-1:0], sz, sy, sx};
  endfunction

  assign steps_pending = step_queue.size();

  always @(posedge clk) begin
    logic [87:0] want;
    if (!rst_n) begin
      accel_lim <= vsal_pkg::AccelRst;
      speed_lim <= vsal_pkg::SpeedRst;
      prev_len = '0;
      step_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == vsal_pkg::CfgAccel) accel_lim <= cfg_wdata;
        else speed_lim <= cfg_wdata;
      end
      if (in_tvalid && in_tready) step_queue.push_back(limited_step(in_tdata));
      if (out_tvalid && out_tready) begin
        if (step_queue.size() == 0) begin
          $display("%0t: unexpected step %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = step_queue.pop_front();
          if (want[20:0] !== out_tdata[20:0] || want[41:21] !== out_tdata[41:21] ||
              want[62:42] !== out_tdata[62:42] || want[82:63] !== out_tdata[82:63]) begin
            $display("%0t: step mismatch expected %h actual %h", $time, want, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the vector step limiter: stimulus, configuration and verdict.
module tb_top;
  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [71:0] in_tdata;
  logic [87:0] out_tdata;
  logic cfg_we, cfg_index;
  logic [19:0] cfg_wdata;
  int fail_count, steps_pending;
  int send_idle_pct, recv_idle_pct, hold_cycles;
  longint cycles;

  vector_step_speed_accel_limiter dut (.*);
  step_limit_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stall, plus long hold-offs on request.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 0;
    end else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [23:0] rand_comp();
    case ($urandom_range(5))
      0: return 24'($urandom_range(2000)) - 24'd1000;
      1: return 24'($urandom_range(40000)) - 24'd20000;
      2: return 24'h800000;
      3: return 24'h7fffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // Leaves in_tvalid high after the handshake; the next call puts new data on it or drops it, or the caller drops it.
  task automatic send_disp(input logic [23:0] x, y, z);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) begin
      in_tvalid <= 0;
      @(posedge clk);
      gap++;
    end
    in_tvalid <= 1;
    in_tdata <= {z, y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic idx, input logic [19:0] v);
    in_tvalid <= 0;
    @(posedge clk);
    while (steps_pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    send_idle_pct = 31;
    recv_idle_pct = 88;
    hold_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: zero vector, extremes, ramp-up, sudden drop.
    send_disp(0, 0, 0);
    send_disp(24'h7fffff, 0, 0);
    send_disp(24'h800000, 24'h800000, 24'h800000);
    send_disp(24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_disp(0, 24'h800000, 0);
    send_disp(0, 0, 24'hffffff);
    send_disp(3, -24'd4, 0);
    send_disp(24'd50000, 24'd50000, -24'd50000);
    send_disp(24'd50000, 24'd50000, -24'd50000);
    send_disp(24'd10, 0, 0);
    send_disp(0, 0, 0);
    write_reg(vsal_pkg::CfgAccel, 20'hfffff);
    write_reg(vsal_pkg::CfgSpeed, 20'hfffff);
    send_disp(24'h800000, 24'h800000, 24'h800000);
    send_disp(24'h7fffff, 24'h800000, 24'h7fffff);
    send_disp(-24'd1, 24'd1, -24'd1);
    write_reg(vsal_pkg::CfgAccel, 0);
    write_reg(vsal_pkg::CfgSpeed, 0);
    send_disp(24'd1000, 24'd1000, 24'd1000);
    send_disp(0, 0, 0);
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 31; recv_idle_pct = 88; end
        2: begin send_idle_pct = 88; recv_idle_pct = 31; end
        4: begin send_idle_pct = 0; recv_idle_pct = 0; end
        default: ;
      endcase
      write_reg(vsal_pkg::CfgAccel, (ph == 1) ? 20'd0 : 20'($urandom_range(ph * 3000)));
      write_reg(vsal_pkg::CfgSpeed,
                (ph == 5) ? 20'hfffff : 20'($urandom_range(20000 + ph * 200000)));
      if (ph == 4) hold_cycles = 3000;
      for (int i = 0; i < 315; i++) send_disp(rand_comp(), rand_comp(), rand_comp());
    end
    in_tvalid <= 0;
    @(posedge clk);
    while (steps_pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
